@@ sv/tac_pkg.sv @@
package tac_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_TIMEOUT  = 1'b0;
   localparam logic REG_DEADTIME = 1'b1;

   localparam logic [15:0] TIMEOUT_MIN    = 16'd500;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;
   localparam logic [8:0]  DEADTIME_MAX   = 9'd500;
   localparam logic [8:0]  DEADTIME_RESET = 9'd50;

   localparam logic [2:0] POS_HIDDEN    = 3'd0;
   localparam logic [2:0] POS_SHOWN     = 3'd1;
   localparam logic [2:0] POS_MOVE_SHOW = 3'd2;
   localparam logic [2:0] POS_MOVE_HIDE = 3'd3;
   localparam logic [2:0] POS_STOPPED   = 3'd4;
   localparam logic [2:0] POS_ERROR     = 3'd5;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_SHOW = 2'd1,
      FUNC_HIDE = 2'd2,
      FUNC_STOP = 2'd3
   } func_type;

   typedef enum logic [5:0] {
      MODE_HIDDEN    = 6'b000001,
      MODE_SHOWN     = 6'b000010,
      MODE_MOVE_SHOW = 6'b000100,
      MODE_MOVE_HIDE = 6'b001000,
      MODE_STOPPED   = 6'b010000,
      MODE_ERROR     = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [8:0]  deadtime_ms;
   } cfg_type;

   typedef struct packed {
      logic       show_relay;
      logic       hide_relay;
      logic [2:0] position_state;
      logic       move_pending;
   } result_type;

   function automatic logic [2:0] mode_code(mode_type m);
      case (m)
         MODE_HIDDEN:    return POS_HIDDEN;
         MODE_SHOWN:     return POS_SHOWN;
         MODE_MOVE_SHOW: return POS_MOVE_SHOW;
         MODE_MOVE_HIDE: return POS_MOVE_HIDE;
         MODE_STOPPED:   return POS_STOPPED;
         default:        return POS_ERROR;
      endcase
   endfunction

endpackage

@@ sv/two_way_actuator_controller.sv @@
// Controller for a two-direction actuator with a show relay, a hide relay and two end sensors.
// Each request transaction carries a function code (tick, show, hide or stop) together with
// both sensor levels, and produces exactly one response transaction holding the relay drive
// levels, the position state and the pending-move flag as they stand after that request.
// Timeout and dead time are set through the APB-style port: timeout at address 0, dead time
// at address 4; they should only be written while no transaction is in flight.
// A request is captured in an input register at the edge that accepts it and is executed once
// the response register is free or being taken; then the state registers and the response
// register are loaded together, so a response passes through the input register and then the
// response register. One request is taken every cycle while responses are not stalled; the
// throughput is set by the single state update per cycle. The response register frees the
// request side: while a response waits, the next request is still captured, and only when the
// response stalls with a request already held does req_ready fall. Reset sets mode hidden,
// relays off, no move pending, timeout 5000 ticks, dead time 50 ticks and no response valid.
module two_way_actuator_controller
   import tac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic                  req_sensor_shown,
   input  logic                  req_sensor_hidden,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_show_relay,
   output logic                  rsp_hide_relay,
   output logic [2:0]            rsp_position_state,
   output logic                  rsp_move_pending,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [1:0] in_func_ff;
   logic       in_shown_ff;
   logic       in_hidden_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       exec;
   logic       req_fire;

   assign exec         = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready    = ~in_valid_ff | exec;
   assign req_fire     = req_valid & req_ready;
   assign in_valid_in  = req_fire | (in_valid_ff & ~exec);
   assign rsp_valid_in = exec | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff   <= req_func;
         in_shown_ff  <= req_sensor_shown;
         in_hidden_ff <= req_sensor_hidden;
      end
      if (exec) begin
         rsp_ff <= result;
      end
   end

   tac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tac_core u_core (
      .clock         (clock),
      .reset         (reset),
      .exec          (exec),
      .func          (func_type'(in_func_ff)),
      .sensor_shown  (in_shown_ff),
      .sensor_hidden (in_hidden_ff),
      .cfg           (cfg),
      .result        (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_show_relay     = rsp_ff.show_relay;
   assign rsp_hide_relay     = rsp_ff.hide_relay;
   assign rsp_position_state = rsp_ff.position_state;
   assign rsp_move_pending   = rsp_ff.move_pending;

endmodule

@@ sv/tac_csr.sv @@
module tac_csr
   import tac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic [8:0]  deadtime_ff;
   logic [8:0]  deadtime_in;
   logic        wr_en;
   logic [15:0] wr_timeout;
   logic [8:0]  wr_deadtime;

   assign csr_pready  = 1'b1;
   assign wr_en       = csr_psel & csr_penable & csr_pwrite;
   assign wr_timeout  = csr_pwdata[15:0];
   assign wr_deadtime = csr_pwdata[8:0];

   always_comb begin
      timeout_in  = timeout_ff;
      deadtime_in = deadtime_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_TIMEOUT: begin
               timeout_in = (wr_timeout < TIMEOUT_MIN) ? TIMEOUT_MIN : wr_timeout;
            end
            REG_DEADTIME: begin
               deadtime_in = (wr_deadtime > DEADTIME_MAX) ? DEADTIME_MAX : wr_deadtime;
            end
            default: begin
               timeout_in = timeout_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         deadtime_ff <= DEADTIME_RESET;
      end else begin
         timeout_ff  <= timeout_in;
         deadtime_ff <= deadtime_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TIMEOUT:  csr_prdata = {{(CSR_DATA_W-16){1'b0}}, timeout_ff};
         REG_DEADTIME: csr_prdata = {{(CSR_DATA_W-9){1'b0}}, deadtime_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.timeout_ms  = timeout_ff;
   assign cfg.deadtime_ms = deadtime_ff;

endmodule

@@ sv/tac_core.sv @@
module tac_core
   import tac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       exec,
   input  func_type   func,
   input  logic       sensor_shown,
   input  logic       sensor_hidden,
   input  cfg_type    cfg,
   output result_type result
);

   mode_type    mode_ff;
   mode_type    mode_in;
   logic        pending_ff;
   logic        pending_in;
   logic        toward_shown_ff;
   logic        toward_shown_in;
   logic [9:0]  pending_ticks_ff;
   logic [9:0]  pending_ticks_in;
   logic [16:0] move_ticks_ff;
   logic [16:0] move_ticks_in;
   logic        show_drive_ff;
   logic        show_drive_in;
   logic        hide_drive_ff;
   logic        hide_drive_in;

   always_comb begin
      logic        moving;
      logic        toward;
      logic        at_target;
      logic        at_end;
      logic [9:0]  pt;
      logic [16:0] mt;

      mode_in          = mode_ff;
      pending_in       = pending_ff;
      toward_shown_in  = toward_shown_ff;
      pending_ticks_in = pending_ticks_ff;
      move_ticks_in    = move_ticks_ff;
      show_drive_in    = show_drive_ff;
      hide_drive_in    = hide_drive_ff;

      moving    = (mode_ff inside {MODE_MOVE_SHOW, MODE_MOVE_HIDE});
      toward    = (func == FUNC_SHOW);
      at_target = toward ? sensor_shown : sensor_hidden;
      at_end    = (mode_ff == MODE_MOVE_SHOW) ? sensor_shown : sensor_hidden;
      pt        = (pending_ticks_ff != '1) ? pending_ticks_ff + 10'd1 : pending_ticks_ff;
      mt        = (move_ticks_ff != '1) ? move_ticks_ff + 17'd1 : move_ticks_ff;

      case (func)
         FUNC_TICK: begin
            if (pending_ff) begin
               pending_ticks_in = pt;
               if (pt >= {1'b0, cfg.deadtime_ms}) begin
                  if (toward_shown_ff) begin
                     show_drive_in = 1'b1;
                     mode_in       = MODE_MOVE_SHOW;
                  end else begin
                     hide_drive_in = 1'b1;
                     mode_in       = MODE_MOVE_HIDE;
                  end
                  move_ticks_in = '0;
                  pending_in    = 1'b0;
               end
            end else if (moving) begin
               if (at_end) begin
                  show_drive_in = 1'b0;
                  hide_drive_in = 1'b0;
                  mode_in       = (mode_ff == MODE_MOVE_SHOW) ? MODE_SHOWN : MODE_HIDDEN;
               end else begin
                  move_ticks_in = mt;
                  if (mt > {1'b0, cfg.timeout_ms}) begin
                     show_drive_in = 1'b0;
                     hide_drive_in = 1'b0;
                     mode_in       = MODE_ERROR;
                  end
               end
            end
         end
         FUNC_SHOW, FUNC_HIDE: begin
            if (mode_ff != MODE_ERROR) begin
               if (at_target) begin
                  pending_in    = 1'b0;
                  show_drive_in = 1'b0;
                  hide_drive_in = 1'b0;
                  mode_in       = toward ? MODE_SHOWN : MODE_HIDDEN;
               end else begin
                  if (toward) begin
                     hide_drive_in = 1'b0;
                  end else begin
                     show_drive_in = 1'b0;
                  end
                  pending_in       = 1'b1;
                  toward_shown_in  = toward;
                  pending_ticks_in = '0;
               end
            end
         end
         default: begin
            pending_in    = 1'b0;
            show_drive_in = 1'b0;
            hide_drive_in = 1'b0;
            if (sensor_shown) begin
               mode_in = MODE_SHOWN;
            end else if (sensor_hidden) begin
               mode_in = MODE_HIDDEN;
            end else if (moving || pending_ff) begin
               mode_in = MODE_STOPPED;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_HIDDEN;
         pending_ff       <= 1'b0;
         toward_shown_ff  <= 1'b0;
         pending_ticks_ff <= '0;
         move_ticks_ff    <= '0;
         show_drive_ff    <= 1'b0;
         hide_drive_ff    <= 1'b0;
      end else if (exec) begin
         mode_ff          <= mode_in;
         pending_ff       <= pending_in;
         toward_shown_ff  <= toward_shown_in;
         pending_ticks_ff <= pending_ticks_in;
         move_ticks_ff    <= move_ticks_in;
         show_drive_ff    <= show_drive_in;
         hide_drive_ff    <= hide_drive_in;
      end
   end

   assign result.show_relay     = show_drive_in;
   assign result.hide_relay     = hide_drive_in;
   assign result.position_state = mode_code(mode_in);
   assign result.move_pending   = pending_in;

endmodule

@@ sv/tac_checker.sv @@
module tac_checker
   import tac_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_show_relay,
   input logic                  rsp_hide_relay,
   input logic [2:0]            rsp_position_state,
   input logic                  rsp_move_pending
);

   // A stalled response transaction must hold its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_show_relay)
         && $stable(rsp_hide_relay) && $stable(rsp_position_state)
         && $stable(rsp_move_pending))
      else $error("response changed while stalled");

   // Both relays must never be driven at once.
   a_no_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_show_relay && rsp_hide_relay))
      else $error("both relays driven");

   // In the error state nothing is driven and no move is queued.
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_position_state == POS_ERROR
         |-> !rsp_show_relay && !rsp_hide_relay && !rsp_move_pending)
      else $error("activity in error state");

   // No response can appear in the cycle straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind two_way_actuator_controller tac_checker u_checker (.*);
